// File: rtl/core/ucrr_pkg.sv
// ----------------------------------------------------------------------------
// ucrr_pkg
// Shared types, constants and descriptor ROM of the control request responder.
// ----------------------------------------------------------------------------
package ucrr_pkg;

  localparam int CtrlPktBytesDef   = 64;
  localparam int BulkPktBytesDef   = 160;
  localparam int NotifyPktBytesDef = 8;

  localparam int CfgLen = 67;

  // Event codes
  localparam logic [1:0] OP_SETUP    = 2'd0;
  localparam logic [1:0] OP_OUT      = 2'd1;
  localparam logic [1:0] OP_IN_SENT  = 2'd2;
  localparam logic [1:0] OP_BUS_RST  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ZLP   = 2'd1;
  localparam logic [1:0] KIND_STALL = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // ROM sources
  localparam logic [3:0] SRC_DEV    = 4'd0;
  localparam logic [3:0] SRC_CFG    = 4'd1;
  localparam logic [3:0] SRC_LANG   = 4'd2;
  localparam logic [3:0] SRC_ONE_CN = 4'd3;
  localparam logic [3:0] SRC_TWO_CN = 4'd4;
  localparam logic [3:0] SRC_ONE_EN = 4'd5;
  localparam logic [3:0] SRC_TWO_EN = 4'd6;
  localparam logic [3:0] SRC_OTHER  = 4'd7;
  localparam logic [3:0] SRC_CODING = 4'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [31:0] out_rate;
    logic [7:0]  out_stop_bits;
    logic [7:0]  out_parity;
    logic [7:0]  out_data_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [6:0]  device_address;
    logic [15:0] line_state;
    logic [31:0] line_rate;
    logic [7:0]  line_stop_bits;
    logic [7:0]  line_parity;
    logic [7:0]  line_data_bits;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic       decode;   // latch request, apply its state update
    logic       emit;     // present a word on the output register
    logic [1:0] kind;
    logic       last;
    logic       advance;  // step byte index
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       stream;    // decoded request sends bytes
    logic [1:0] kind;      // single-word kind when not streaming
    logic       final_byte;
    logic       out_busy;
  } dp_sts_t;

  function automatic logic [7:0] rom_byte(input logic [3:0] src, input logic [6:0] i,
                                          input logic [7:0] mps, input logic [15:0] bulk,
                                          input logic [15:0] ntf);
    logic [7:0] b;
    b = 8'h00;
    unique case (src)
      SRC_DEV: begin
        unique case (i)
          7'd0: b = 8'h12; 7'd1: b = 8'h01; 7'd2: b = 8'h00; 7'd3: b = 8'h02;
          7'd4: b = 8'h02; 7'd5: b = 8'h02; 7'd6: b = 8'h00; 7'd7: b = mps;
          7'd8: b = 8'h83; 7'd9: b = 8'h04; 7'd10: b = 8'h40; 7'd11: b = 8'h57;
          7'd12: b = 8'h00; 7'd13: b = 8'h02; 7'd14: b = 8'h01; 7'd15: b = 8'h02;
          7'd16: b = 8'h00; 7'd17: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SRC_CFG: begin
        unique case (i)
          7'd0: b = 8'h09; 7'd1: b = 8'h02; 7'd2: b = 8'h43; 7'd3: b = 8'h00;
          7'd4: b = 8'h02; 7'd5: b = 8'h01; 7'd6: b = 8'h00; 7'd7: b = 8'hC0;
          7'd8: b = 8'h32;
          7'd9: b = 8'h09; 7'd10: b = 8'h04; 7'd11: b = 8'h00; 7'd12: b = 8'h00;
          7'd13: b = 8'h01; 7'd14: b = 8'h02; 7'd15: b = 8'h02; 7'd16: b = 8'h01;
          7'd17: b = 8'h00;
          7'd18: b = 8'h05; 7'd19: b = 8'h24; 7'd20: b = 8'h00; 7'd21: b = 8'h10;
          7'd22: b = 8'h01;
          7'd23: b = 8'h05; 7'd24: b = 8'h24; 7'd25: b = 8'h01; 7'd26: b = 8'h00;
          7'd27: b = 8'h01;
          7'd28: b = 8'h04; 7'd29: b = 8'h24; 7'd30: b = 8'h02; 7'd31: b = 8'h02;
          7'd32: b = 8'h05; 7'd33: b = 8'h24; 7'd34: b = 8'h06; 7'd35: b = 8'h00;
          7'd36: b = 8'h01;
          7'd37: b = 8'h07; 7'd38: b = 8'h05; 7'd39: b = 8'h82; 7'd40: b = 8'h03;
          7'd41: b = ntf[7:0]; 7'd42: b = ntf[15:8]; 7'd43: b = 8'h10;
          7'd44: b = 8'h09; 7'd45: b = 8'h04; 7'd46: b = 8'h01; 7'd47: b = 8'h00;
          7'd48: b = 8'h02; 7'd49: b = 8'h0A; 7'd50: b = 8'h00; 7'd51: b = 8'h00;
          7'd52: b = 8'h00;
          7'd53: b = 8'h07; 7'd54: b = 8'h05; 7'd55: b = 8'h01; 7'd56: b = 8'h02;
          7'd57: b = bulk[7:0]; 7'd58: b = bulk[15:8]; 7'd59: b = 8'h00;
          7'd60: b = 8'h07; 7'd61: b = 8'h05; 7'd62: b = 8'h81; 7'd63: b = 8'h02;
          7'd64: b = bulk[7:0]; 7'd65: b = bulk[15:8]; 7'd66: b = 8'h00;
          default: b = 8'h00;
        endcase
      end
      SRC_LANG: begin
        unique case (i)
          7'd0: b = 8'h06; 7'd1: b = 8'h03; 7'd2: b = 8'h04; 7'd3: b = 8'h08;
          7'd4: b = 8'h09; 7'd5: b = 8'h04;
          default: b = 8'h00;
        endcase
      end
      SRC_ONE_CN: begin
        unique case (i)
          7'd0: b = 8'h0E; 7'd1: b = 8'h03; 7'd2: b = 8'hBA; 7'd3: b = 8'h4E;
          7'd4: b = 8'h4B; 7'd5: b = 8'h4E; 7'd6: b = 8'h1D; 7'd7: b = 8'h52;
          7'd8: b = 8'h27; 7'd9: b = 8'h60; 7'd10: b = 8'h2C; 7'd11: b = 8'h67;
          7'd12: b = 8'h84; 7'd13: b = 8'h55;
          default: b = 8'h00;
        endcase
      end
      SRC_TWO_CN: begin
        unique case (i)
          7'd0: b = 8'h0E; 7'd1: b = 8'h03; 7'd2: b = 8'h27; 7'd3: b = 8'h60;
          7'd4: b = 8'hF8; 7'd5: b = 8'h76; 7'd6: b = 8'hD1; 7'd7: b = 8'h8F;
          7'd8: b = 8'h60; 7'd9: b = 8'h4E; 7'd10: b = 8'hF8; 7'd11: b = 8'h76;
          7'd12: b = 8'hDC; 7'd13: b = 8'h8F;
          default: b = 8'h00;
        endcase
      end
      SRC_ONE_EN: begin
        unique case (i)
          7'd0: b = 8'h10; 7'd1: b = 8'h03; 7'd2: b = 8'h53; 7'd4: b = 8'h54;
          7'd6: b = 8'h4D; 7'd8: b = 8'h69; 7'd10: b = 8'h63; 7'd12: b = 8'h72;
          7'd14: b = 8'h6F;
          default: b = 8'h00;
        endcase
      end
      SRC_TWO_EN: begin
        unique case (i)
          7'd0: b = 8'h1C; 7'd1: b = 8'h03; 7'd2: b = 8'h53; 7'd4: b = 8'h54;
          7'd6: b = 8'h4D; 7'd8: b = 8'h33; 7'd10: b = 8'h32; 7'd12: b = 8'h46;
          7'd14: b = 8'h31; 7'd16: b = 8'h30; 7'd18: b = 8'h33; 7'd20: b = 8'h43;
          7'd22: b = 8'h38; 7'd24: b = 8'h54; 7'd26: b = 8'h36;
          default: b = 8'h00;
        endcase
      end
      SRC_OTHER: begin
        unique case (i)
          7'd0: b = 8'h0A; 7'd1: b = 8'h03; 7'd2: b = 8'h11; 7'd3: b = 8'h62;
          7'd4: b = 8'h0D; 7'd5: b = 8'h4E; 7'd6: b = 8'hE5; 7'd7: b = 8'h77;
          7'd8: b = 8'h53; 7'd9: b = 8'h90;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/ucrr_ctrl.sv
// ----------------------------------------------------------------------------
// ucrr_ctrl
// Sequencer: takes a request word, has the datapath decode it, then emits
// either a single status word or a run of packet bytes.
// ----------------------------------------------------------------------------
module ucrr_ctrl import ucrr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.decode = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts.out_busy) begin
          if (sts.stream) begin
            state_next = ST_STREAM;
          end else begin
            cmd.emit = 1'b1;
            cmd.kind = sts.kind;
            cmd.last = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_STREAM: begin
        if (!sts.out_busy) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_DATA;
          cmd.last    = sts.final_byte;
          cmd.advance = 1'b1;
          if (sts.final_byte) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/ucrr_dp.sv
// ----------------------------------------------------------------------------
// ucrr_dp
// Datapath: request decode, endpoint state, descriptor byte selection and
// the output register.
// ----------------------------------------------------------------------------
module ucrr_dp import ucrr_pkg::*; #(
  parameter int CTRL_PKT_BYTES   = CtrlPktBytesDef,
  parameter int BULK_PKT_BYTES   = BulkPktBytesDef,
  parameter int NOTIFY_PKT_BYTES = NotifyPktBytesDef
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output rsp_t    rsp,
  output logic    rsp_valid,
  input  logic    rsp_ready
);

  localparam logic [7:0]  Mps  = 8'(CTRL_PKT_BYTES);
  localparam logic [15:0] Bulk = 16'(BULK_PKT_BYTES);
  localparam logic [15:0] Ntf  = 16'(NOTIFY_PKT_BYTES);

  // Endpoint state
  logic        coding_pending;
  logic [6:0]  pending_address;
  logic [6:0]  applied_address;
  logic [7:0]  bytes_remaining;
  logic [6:0]  send_offset;
  logic [15:0] stored_line_state;
  logic [31:0] stored_rate;
  logic [7:0]  stored_stop_bits;
  logic [7:0]  stored_parity;
  logic [7:0]  stored_data_bits;

  // Per request stream
  logic [3:0] src;
  logic [6:0] base;
  logic [6:0] idx;
  logic [6:0] cnt;
  logic       stream;
  logic [1:0] kind_one;

  // Decode of the incoming word
  logic       d_stream;
  logic [1:0] d_kind;
  logic [3:0] d_src;
  logic [6:0] d_cnt;
  logic       d_chunk;       // configuration chunk from remainder
  logic       d_cfg_start;
  logic [7:0] d_rem;
  logic [7:0] chunk_n;
  logic [7:0] sel;

  assign sel = req.request_value[7:0];

  always_comb begin
    d_stream    = 1'b0;
    d_kind      = KIND_ZLP;
    d_src       = SRC_DEV;
    d_cnt       = '0;
    d_chunk     = 1'b0;
    d_cfg_start = 1'b0;
    d_rem       = bytes_remaining;
    unique case (req.operation)
      OP_SETUP: begin
        priority if (req.request_type == 8'h80 && req.request_code == 8'h06) begin
          unique case (req.request_value[15:8])
            8'd1: begin d_stream = 1'b1; d_src = SRC_DEV; d_cnt = 7'd18; end
            8'd2: begin
              d_cfg_start = 1'b1;
              d_rem = (req.request_length < 16'(CfgLen)) ?
                      req.request_length[7:0] : 8'(CfgLen);
              d_chunk = 1'b1;
            end
            8'd3: begin
              d_stream = 1'b1;
              priority if (sel == 8'd0) begin
                d_src = SRC_LANG; d_cnt = 7'd6;
              end else if (sel == 8'd1) begin
                d_src = (req.request_index == 16'h0804) ? SRC_ONE_CN : SRC_ONE_EN;
                d_cnt = (req.request_index == 16'h0804) ? 7'd14 : 7'd16;
              end else if (sel == 8'd2) begin
                d_src = (req.request_index == 16'h0804) ? SRC_TWO_CN : SRC_TWO_EN;
                d_cnt = (req.request_index == 16'h0804) ? 7'd14 : 7'd28;
              end else begin
                d_src = SRC_OTHER; d_cnt = 7'd10;
              end
            end
            8'd6: d_kind = KIND_STALL;
            default: d_kind = KIND_ZLP;
          endcase
        end else if (req.request_type == 8'hA1 && req.request_code == 8'h21) begin
          d_stream = 1'b1; d_src = SRC_CODING; d_cnt = 7'd7;
        end else if (req.request_type == 8'h21 && req.request_code == 8'h20) begin
          d_kind = KIND_NONE;
        end else begin
          d_kind = KIND_ZLP;
        end
      end
      OP_OUT:     d_kind = coding_pending ? KIND_ZLP : KIND_NONE;
      OP_IN_SENT: begin
        if (bytes_remaining != 8'd0) begin
          d_chunk = 1'b1;
        end else begin
          d_kind = KIND_NONE;
        end
      end
      default: d_kind = KIND_NONE;
    endcase
    chunk_n = (d_rem > Mps) ? Mps : d_rem;
    if (d_chunk) begin
      d_src = SRC_CFG;
      if (chunk_n == 8'd0) begin
        d_kind = KIND_ZLP;
      end else begin
        d_stream = 1'b1;
        d_cnt    = chunk_n[6:0];
      end
    end
  end

  // State update on decode
  always_ff @(posedge clk) begin
    if (rst) begin
      coding_pending    <= 1'b0;
      pending_address   <= '0;
      applied_address   <= '0;
      bytes_remaining   <= '0;
      send_offset       <= '0;
      stored_line_state <= '0;
      stored_rate       <= '0;
      stored_stop_bits  <= '0;
      stored_parity     <= '0;
      stored_data_bits  <= '0;
    end else if (cmd.decode) begin
      unique case (req.operation)
        OP_SETUP: begin
          if (req.request_type == 8'h00 && req.request_code == 8'h05) begin
            pending_address <= req.request_value[6:0];
          end
          if (req.request_type == 8'h21 && req.request_code == 8'h22) begin
            stored_line_state <= req.request_value;
          end
          if (req.request_type == 8'h21 && req.request_code == 8'h20) begin
            coding_pending <= 1'b1;
          end
        end
        OP_OUT: begin
          if (coding_pending) begin
            stored_rate      <= req.out_rate;
            stored_stop_bits <= req.out_stop_bits;
            stored_parity    <= req.out_parity;
            stored_data_bits <= req.out_data_bits;
            coding_pending   <= 1'b0;
          end
        end
        OP_IN_SENT: begin
          if (pending_address != 7'd0) begin
            applied_address <= pending_address;
            pending_address <= '0;
          end
        end
        default: applied_address <= '0;
      endcase
      if (d_chunk) begin
        bytes_remaining <= d_rem - chunk_n;
        send_offset     <= (d_cfg_start ? 7'd0 : send_offset) + chunk_n[6:0];
      end else if (d_cfg_start) begin
        bytes_remaining <= d_rem;
        send_offset     <= '0;
      end
    end
  end

  // Stream registers
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      src      <= d_src;
      cnt      <= d_cnt;
      idx      <= '0;
      stream   <= d_stream;
      kind_one <= d_kind;
      base     <= d_cfg_start ? 7'd0 : send_offset;
    end else if (cmd.advance) begin
      idx <= idx + 7'd1;
    end
  end

  // Byte selection
  logic [6:0] pos;
  logic [7:0] byte_sel;
  assign pos = (src == SRC_CFG) ? base + idx : idx;

  always_comb begin
    if (src == SRC_CODING) begin
      unique case (idx[2:0])
        3'd0: byte_sel = stored_rate[7:0];
        3'd1: byte_sel = stored_rate[15:8];
        3'd2: byte_sel = stored_rate[23:16];
        3'd3: byte_sel = stored_rate[31:24];
        3'd4: byte_sel = stored_stop_bits;
        3'd5: byte_sel = stored_parity;
        3'd6: byte_sel = stored_data_bits;
        default: byte_sel = 8'h00;
      endcase
    end else begin
      byte_sel = rom_byte(src, pos, Mps, Bulk, Ntf);
    end
  end

  assign sts.stream     = stream;
  assign sts.kind       = kind_one;
  assign sts.final_byte = (idx + 7'd1 == cnt);
  assign sts.out_busy   = rsp_valid && !rsp_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.kind           <= cmd.kind;
      rsp.data_byte      <= (cmd.kind == KIND_DATA) ? byte_sel : 8'h00;
      rsp.last           <= cmd.last;
      rsp.device_address <= applied_address;
      rsp.line_state     <= stored_line_state;
      rsp.line_rate      <= stored_rate;
      rsp.line_stop_bits <= stored_stop_bits;
      rsp.line_parity    <= stored_parity;
      rsp.line_data_bits <= stored_data_bits;
    end
  end

endmodule

// File: rtl/core/usb_control_request_responder_top.sv
// ----------------------------------------------------------------------------
// usb_control_request_responder_top
// Endpoint 0 responder of a CDC-ACM device: sequencer plus datapath.
// Request handling: a request word is taken in IDLE and decoded; a single status
// word is registered from DECIDE, the bytes of a packet from STREAM, each held
// while the sink holds a word back. A new request is taken only after the last
// word of the previous one is emitted; a packet holds 1 to 64 bytes.
// Reset: synchronous; all endpoint state and line coding clear to zero.
// ----------------------------------------------------------------------------
module usb_control_request_responder_top import ucrr_pkg::*; #(
  parameter int CTRL_PKT_BYTES   = CtrlPktBytesDef,
  parameter int BULK_PKT_BYTES   = BulkPktBytesDef,
  parameter int NOTIFY_PKT_BYTES = NotifyPktBytesDef
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  req_t    req;

  // Request word held while its results go out
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  ucrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucrr_dp #(
    .CTRL_PKT_BYTES   (CTRL_PKT_BYTES),
    .BULK_PKT_BYTES   (BULK_PKT_BYTES),
    .NOTIFY_PKT_BYTES (NOTIFY_PKT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       ((in_valid && in_ready) ? in_data : req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (out_data),
    .rsp_valid (out_valid),
    .rsp_ready (out_ready)
  );

endmodule
